// ----- hdl/espe_pkg.sv -----
// ----------------------------------------------------------------------------
// espe_pkg
// Shared types, constants and helpers for the encoder speed/position
// estimator: register codes, datapath commands and saturation.
// ----------------------------------------------------------------------------
package espe_pkg;

  localparam int SPEED_W    = 32;
  localparam int ANGLE_W    = 48;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = 50;
  localparam int FSUM_W     = 52;
  localparam int SSCALE_W   = 24;
  localparam int ASCALE_W   = 32;
  localparam int ALPHA_W    = 17;
  localparam int INV_W      = 4;
  localparam int INV_EXT_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_SCALE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK   = 3'd4;

  localparam logic [SSCALE_W-1:0] RST_SPEED_SCALE = 24'd48000;
  localparam logic [ASCALE_W-1:0] RST_ANGLE_SCALE = 32'd411775;
  localparam logic [INV_W-1:0]    RST_INVERT_MASK = 4'd5;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DIFF,
    OP_MUL_SPEED,
    OP_MUL_ANGLE,
    OP_MUL_ALPHA,
    OP_MUL_BETA,
    OP_FILTER,
    OP_ANGLE_ADD
  } op_t;

  typedef struct packed {
    logic load;
    logic publish;
    op_t  op;
  } cmd_t;

  function automatic logic signed [SPEED_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [SPEED_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[SPEED_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/encoder_speed_position_estimator_unit.sv -----
// ----------------------------------------------------------------------------
// encoder_speed_position_estimator_unit
// Per-channel encoder difference, scaled speed with optional moving-average
// filter, and wrapping angle accumulation, one tick per request.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Content
// s_axis    in         s_tvalid/s_tready  one raw counter per channel
// m_axis    out        m_tvalid/m_tready  speeds then angles, all channels
// cfg       in         cfg_we             register index and write data
//
// Every channel in turn runs diff, speed, angle, angle-add (or with filtering
// diff, speed, angle, alpha, beta, filter) on one shared 33x33 multiplier;
// then the result register loads and a new request can be taken. Synchronous
// reset restores register defaults and clears last counts, filter
// state and angle sums. A result waiting on m_tready does not block the next
// request; only a finished request meeting a still-full result register waits.
// ----------------------------------------------------------------------------
module encoder_speed_position_estimator_unit #(
  parameter int CHANNELS   = 4,
  parameter int COUNT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [espe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [espe_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // count_a, count_b, ... each COUNT_BITS wide, zero padded to bytes
  input  logic [((CHANNELS*COUNT_BITS+7)/8)*8-1:0] s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // speed_a, speed_b, ... (32 bit each), then angle_a, angle_b, ... (48 bit each)
  output logic [CHANNELS*(espe_pkg::SPEED_W+espe_pkg::ANGLE_W)-1:0] m_tdata
);
  import espe_pkg::*;

  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IN_DATA_W  = ((CHANNELS*COUNT_BITS+7)/8)*8;
  localparam int OUT_DATA_W = CHANNELS*(SPEED_W+ANGLE_W);

  cmd_t            cmd;
  logic [CH_W-1:0] ch;
  logic            filter_en;

  espe_ctrl #(
    .CHANNELS (CHANNELS),
    .CH_W     (CH_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .filter_en (filter_en),
    .cmd       (cmd),
    .ch        (ch)
  );

  espe_datapath #(
    .CHANNELS   (CHANNELS),
    .COUNT_BITS (COUNT_BITS),
    .CH_W       (CH_W),
    .IN_DATA_W  (IN_DATA_W),
    .OUT_DATA_W (OUT_DATA_W)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .ch        (ch),
    .filter_en (filter_en)
  );

endmodule

// ----- hdl/espe_ctrl.sv -----
// ----------------------------------------------------------------------------
// espe_ctrl
// Sequencer: accepts a request, walks every channel through the shared
// multiplier steps and hands the finished result to the output register.
// ----------------------------------------------------------------------------
module espe_ctrl #(
  parameter int CHANNELS = 4,
  parameter int CH_W     = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  logic               filter_en,
  output espe_pkg::cmd_t     cmd,
  output logic [CH_W-1:0]    ch
);
  import espe_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MSPD,
    ST_MANG,
    ST_MALPHA,
    ST_MBETA,
    ST_FILT,
    ST_ANGADD,
    ST_FINISH
  } state_t;

  state_t state;
  logic   last_ch;
  logic   accept;
  logic   publish;

  assign last_ch  = (ch == CH_W'(CHANNELS - 1));
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign publish  = (state == ST_FINISH) && (!m_tvalid || m_tready);

  always_comb begin
    cmd.load    = accept;
    cmd.publish = publish;
    unique case (state)
      ST_DIFF:   cmd.op = OP_DIFF;
      ST_MSPD:   cmd.op = OP_MUL_SPEED;
      ST_MANG:   cmd.op = OP_MUL_ANGLE;
      ST_MALPHA: cmd.op = OP_MUL_ALPHA;
      ST_MBETA:  cmd.op = OP_MUL_BETA;
      ST_FILT:   cmd.op = OP_FILTER;
      ST_ANGADD: cmd.op = OP_ANGLE_ADD;
      default:   cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ch       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (publish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          ch <= '0;
          if (accept) begin
            state <= ST_DIFF;
          end
        end
        ST_DIFF:   state <= ST_MSPD;
        ST_MSPD:   state <= ST_MANG;
        ST_MANG:   state <= filter_en ? ST_MALPHA : ST_ANGADD;
        ST_MALPHA: state <= ST_MBETA;
        ST_MBETA:  state <= ST_FILT;
        ST_FILT, ST_ANGADD: begin
          // advance to the next channel or finish the request
          if (last_ch) begin
            state <= ST_FINISH;
          end else begin
            ch    <= ch + 1'b1;
            state <= ST_DIFF;
          end
        end
        ST_FINISH: begin
          if (publish) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/espe_datapath.sv -----
// ----------------------------------------------------------------------------
// espe_datapath
// Configuration registers, per-channel state, the shared 33x33 multiplier
// and the output data register.
// ----------------------------------------------------------------------------
module espe_datapath #(
  parameter int CHANNELS   = 4,
  parameter int COUNT_BITS = 16,
  parameter int CH_W       = 2,
  parameter int IN_DATA_W  = 64,
  parameter int OUT_DATA_W = 320
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [espe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [espe_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [IN_DATA_W-1:0]             s_tdata,
  output logic [OUT_DATA_W-1:0]            m_tdata,
  input  espe_pkg::cmd_t                   cmd,
  input  logic [CH_W-1:0]                  ch,
  output logic                             filter_en
);
  import espe_pkg::*;

  // configuration
  logic [SSCALE_W-1:0] speed_scale;
  logic [ASCALE_W-1:0] angle_scale;
  logic [ALPHA_W-1:0]  alpha;
  logic [ALPHA_W-1:0]  beta;
  logic [INV_W-1:0]    invert_mask;

  // per-channel state
  logic [COUNT_BITS-1:0]     in_count   [CHANNELS];
  logic [COUNT_BITS-1:0]     last_count [CHANNELS];
  logic signed [SPEED_W-1:0] smoothed   [CHANNELS];
  logic [ANGLE_W-1:0]        angle_sum  [CHANNELS];
  logic signed [SPEED_W-1:0] speed_res  [CHANNELS];

  // working registers
  logic signed [COUNT_BITS-1:0] diff;
  logic signed [SPEED_W-1:0]    raw;
  logic signed [ACC_W-1:0]      acc;
  logic signed [PROD_W-1:0]     prod;

  logic [INV_EXT_W-1:0]     inv_ext;
  logic [COUNT_BITS-1:0]    cnt_adj;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [FSUM_W-1:0] fsum;
  logic signed [FSUM_W-1:0] fshift;
  logic signed [SPEED_W-1:0] filt;
  logic signed [SPEED_W-1:0] raw_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_scale <= RST_SPEED_SCALE;
      angle_scale <= RST_ANGLE_SCALE;
      alpha       <= ALPHA_ONE;
      beta        <= '0;
      filter_en   <= 1'b0;
      invert_mask <= RST_INVERT_MASK;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPEED_SCALE: speed_scale <= cfg_data[SSCALE_W-1:0];
        REG_ANGLE_SCALE: angle_scale <= cfg_data[ASCALE_W-1:0];
        REG_ALPHA: begin
          // clamp weights above one, keep the complement ready
          if (cfg_data[ALPHA_W-1:0] > ALPHA_ONE) begin
            alpha <= ALPHA_ONE;
            beta  <= '0;
          end else begin
            alpha <= cfg_data[ALPHA_W-1:0];
            beta  <= ALPHA_ONE - cfg_data[ALPHA_W-1:0];
          end
        end
        REG_FILTER_ENABLE: filter_en   <= cfg_data[0];
        REG_INVERT_MASK:   invert_mask <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  assign inv_ext = INV_EXT_W'(invert_mask);
  assign cnt_adj = inv_ext[ch] ? (COUNT_BITS'(0) - in_count[ch]) : in_count[ch];

  always_comb begin
    case (cmd.op)
      OP_MUL_SPEED: begin
        mul_a = MUL_W'(diff);
        mul_b = $signed({{(MUL_W-SSCALE_W){1'b0}}, speed_scale});
      end
      OP_MUL_ANGLE: begin
        mul_a = MUL_W'(diff);
        mul_b = $signed({{(MUL_W-ASCALE_W){1'b0}}, angle_scale});
      end
      OP_MUL_ALPHA: begin
        mul_a = MUL_W'(raw);
        mul_b = $signed({{(MUL_W-ALPHA_W){1'b0}}, alpha});
      end
      default: begin
        mul_a = MUL_W'(smoothed[ch]);
        mul_b = $signed({{(MUL_W-ALPHA_W){1'b0}}, beta});
      end
    endcase
  end

  assign raw_sat = sat32($signed(prod[63:0]));
  assign fsum    = FSUM_W'(acc) + FSUM_W'($signed(prod[ACC_W-1:0])) + FSUM_W'(32768);
  assign fshift  = fsum >>> 16;
  assign filt    = sat32(64'(fshift));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_count[i] <= '0;
        smoothed[i]   <= '0;
        angle_sum[i]  <= '0;
      end
    end else begin
      case (cmd.op)
        OP_DIFF: begin
          last_count[ch] <= cnt_adj;
        end
        OP_MUL_ALPHA, OP_ANGLE_ADD: begin
          angle_sum[ch] <= angle_sum[ch] + prod[ANGLE_W-1:0];
        end
        OP_FILTER: begin
          smoothed[ch] <= filt;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < CHANNELS; i++) begin
        in_count[i] <= s_tdata[i*COUNT_BITS +: COUNT_BITS];
      end
    end
    if (cmd.op != OP_NONE && cmd.op != OP_DIFF) begin
      prod <= mul_a * mul_b;
    end
    case (cmd.op)
      OP_DIFF:      diff          <= $signed(cnt_adj - last_count[ch]);
      OP_MUL_ANGLE: raw           <= raw_sat;
      OP_MUL_BETA:  acc           <= $signed(prod[ACC_W-1:0]);
      OP_FILTER:    speed_res[ch] <= filt;
      OP_ANGLE_ADD: speed_res[ch] <= raw;
      default: ;
    endcase
    if (cmd.publish) begin
      for (int i = 0; i < CHANNELS; i++) begin
        m_tdata[i*SPEED_W +: SPEED_W]                    <= speed_res[i];
        m_tdata[CHANNELS*SPEED_W + i*ANGLE_W +: ANGLE_W] <= angle_sum[i];
      end
    end
  end

endmodule

// ----- hdl/espe_checker.sv -----
// ----------------------------------------------------------------------------
// espe_checker
// Port-level checks of the estimator: result hold under stall, reset and
// the one-request-at-a-time sequencing.
// ----------------------------------------------------------------------------
module espe_checker #(
  parameter int OUT_DATA_W = 320
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("new request taken while one is in work");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid)
    else $error("result appeared without processing time");

endmodule

bind encoder_speed_position_estimator_unit espe_checker #(
  .OUT_DATA_W (OUT_DATA_W)
) u_espe_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/sv/encoder_speed_position_estimator_unit_tb.sv -----
// ----------------------------------------------------------------------------
// encoder_speed_position_estimator_unit_tb
// Self-checking bench for the four-channel encoder speed/position estimator.
// Every accepted tick is run through a local model of the datapath. The
// model covers the wrapped count difference, the optional count negation,
// the saturated speed, the moving-average filter and the wrapping angle sum.
// Each result on the output stream is compared, channel by channel, against
// the oldest prediction. Directed ticks cover count extremes, scale extremes
// and filter weights. Random ticks follow register settings that change
// between phases, with bursty input and a receiver that stalls at random.
// ----------------------------------------------------------------------------
module encoder_speed_position_estimator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import espe_pkg::*;

  localparam int NUM_CH          = 4;
  localparam int CNT_W           = 16;
  localparam int HALF_PERIOD     = 10;
  localparam int LAT_CYCLES      = 6 * NUM_CH + 2;
  localparam int HOLDOFF_CYCLES  = 500;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int REPORT_MAX      = 10;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 75;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  localparam longint SPEED_MAX = 64'sd2147483647;
  localparam longint SPEED_MIN = -64'sd2147483648;

  localparam logic [NUM_CH-1:0][CNT_W-1:0] CORNER_COUNTS =
    {16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000};

  typedef logic [NUM_CH-1:0][CNT_W-1:0] tick_counts_t;

  typedef struct packed {
    logic [NUM_CH-1:0][ANGLE_W-1:0] angle;
    logic [NUM_CH-1:0][SPEED_W-1:0] speed;
  } tick_result_t;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_COMB, SINK_SPARSE} sink_mode_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  // count_a, count_b, count_c, count_d (16 bit each)
  logic [NUM_CH*CNT_W-1:0] s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  // speed_a..speed_d (32 bit each), then angle_a..angle_d (48 bit each)
  logic [NUM_CH*(SPEED_W+ANGLE_W)-1:0] m_tdata;

  // register mirror
  logic [SSCALE_W-1:0] scale_speed;
  logic [ASCALE_W-1:0] scale_angle;
  logic [ALPHA_W-1:0]  alpha_weight;
  logic                filter_on;
  logic [INV_W-1:0]    invert_bits;

  // per-channel state
  logic [CNT_W-1:0]          prev_count   [NUM_CH];
  logic signed [SPEED_W-1:0] smooth_speed [NUM_CH];
  logic [ANGLE_W-1:0]        angle_acc    [NUM_CH];

  tick_result_t expected_ticks[$];
  tick_counts_t enc_pos = '0;
  int mismatch_count = 0;
  int holdoff_reqs   = 0;
  int holdoff_served = 0;

  encoder_speed_position_estimator_unit #(
    .CHANNELS  (NUM_CH),
    .COUNT_BITS(CNT_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  // ---------------------------------------------------------------- model
  function automatic void restore_defaults();
    scale_speed  = RST_SPEED_SCALE;
    scale_angle  = RST_ANGLE_SCALE;
    alpha_weight = ALPHA_ONE;
    filter_on    = 1'b0;
    invert_bits  = RST_INVERT_MASK;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prev_count[ch]   = '0;
      smooth_speed[ch] = '0;
      angle_acc[ch]    = '0;
    end
  endfunction

  function automatic void mirror_register(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_SPEED_SCALE:   scale_speed  = data[SSCALE_W-1:0];
      REG_ANGLE_SCALE:   scale_angle  = data[ASCALE_W-1:0];
      REG_ALPHA:         alpha_weight = data[ALPHA_W-1:0];
      REG_FILTER_ENABLE: filter_on    = data[0];
      REG_INVERT_MASK:   invert_bits  = data[INV_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > SPEED_MAX) return SPEED_MAX;
    if (v < SPEED_MIN) return SPEED_MIN;
    return v;
  endfunction

  function automatic tick_result_t estimate_tick(input tick_counts_t counts);
    tick_result_t r;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] delta;
    longint diff;
    longint raw;
    longint mixed;
    longint step;
    longint a;
    a = (alpha_weight > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_weight);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      cnt = counts[ch];
      if (invert_bits[ch]) cnt = 16'd0 - cnt;
      delta = cnt - prev_count[ch];
      diff  = longint'($signed(delta));
      prev_count[ch] = cnt;
      raw = clamp32(diff * longint'(scale_speed));
      if (filter_on) begin
        // weighted sum, round half up, floor on the way down
        mixed = a * raw + (longint'(ALPHA_ONE) - a) * longint'(smooth_speed[ch]) + 32768;
        mixed = clamp32(mixed >>> 16);
        smooth_speed[ch] = mixed[SPEED_W-1:0];
        r.speed[ch] = smooth_speed[ch];
      end else begin
        r.speed[ch] = raw[SPEED_W-1:0];
      end
      step = diff * longint'(scale_angle);
      angle_acc[ch] = angle_acc[ch] + step[ANGLE_W-1:0];
      r.angle[ch] = angle_acc[ch];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_tick(input tick_counts_t counts);
    s_tvalid <= 1'b1;
    s_tdata  <= counts;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_ticks.push_back(estimate_tick(counts));
  endtask

  task automatic pause(input int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    mirror_register(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic tick_counts_t spread(input logic [CNT_W-1:0] v);
    return {v ^ 16'h8000, v + 16'd3, ~v, v};
  endfunction

  // mostly smooth encoder motion, some noise and corner counts
  function automatic tick_counts_t next_counts(input int span);
    tick_counts_t c;
    int sel;
    sel = $urandom_range(99);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (sel < 75) c[ch] = enc_pos[ch] + 16'($urandom_range(2 * span) - span);
      else if (sel < 92) c[ch] = 16'($urandom);
      else c[ch] = CORNER_COUNTS[$urandom_range(NUM_CH - 1)];
    end
    enc_pos = c;
    return c;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input logic [CFG_IDX_W-1:0] idx);
    logic [CFG_DATA_W-1:0] v;
    v = $urandom;   // bits above each register width ride along as junk
    case (idx)
      REG_SPEED_SCALE: begin
        case ($urandom_range(3))
          0: v[SSCALE_W-1:0] = '0;
          1: v[SSCALE_W-1:0] = '1;
          2: v[SSCALE_W-1:0] = SSCALE_W'($urandom_range(65535));
          default: ;
        endcase
      end
      REG_ANGLE_SCALE: begin
        case ($urandom_range(3))
          0: v = '0;
          1: v = '1;
          2: v = $urandom_range(1 << 22);
          default: ;
        endcase
      end
      REG_ALPHA: begin
        case ($urandom_range(3))
          0: v[ALPHA_W-1:0] = '0;
          1: v[ALPHA_W-1:0] = ALPHA_ONE;
          2: v[ALPHA_W-1:0] = ALPHA_W'($urandom_range(65536));
          default: ;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------- receiver
  initial begin : result_sink
    sink_mode_t mode;
    int left;
    int tick;
    mode = SINK_OPEN;
    left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (holdoff_reqs != holdoff_served) begin
        // hold off long enough for the input side to back up
        holdoff_served++;
        m_tready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = sink_mode_t'($urandom_range(SINK_SPARSE));
          left = $urandom_range(150, 10);
        end
        left--;
        case (mode)
          SINK_OPEN:  m_tready <= 1'b1;
          SINK_COIN:  m_tready <= ($urandom_range(1) == 1);
          SINK_COMB:  m_tready <= ((tick % 5) != 0);
          default:    m_tready <= ($urandom_range(7) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- checker
  function automatic void flag_mismatch(input string what, input int ch,
                                        input logic [ANGLE_W-1:0] want,
                                        input logic [ANGLE_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("%0t: %s ch%0d expected %h got %h", $time, what, ch, want, got);
  endfunction

  always @(posedge clk) begin : check_results
    tick_result_t got;
    tick_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = tick_result_t'(m_tdata);
      if (expected_ticks.size() == 0) begin
        flag_mismatch("result with no request pending", 0, '0, got.angle[0]);
      end else begin
        want = expected_ticks.pop_front();
        for (int ch = 0; ch < NUM_CH; ch++) begin
          if (got.speed[ch] !== want.speed[ch])
            flag_mismatch("speed", ch, ANGLE_W'(want.speed[ch]), ANGLE_W'(got.speed[ch]));
          if (got.angle[ch] !== want.angle[ch])
            flag_mismatch("angle", ch, want.angle[ch], got.angle[ch]);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------- tests
  // zero, unit steps, wrap through zero and half-range jumps at reset settings
  task automatic test_default_ticks();
    send_tick(spread(16'h0000));
    send_tick(spread(16'h0001));
    send_tick(spread(16'hFFFF));
    send_tick(spread(16'h7FFF));
    send_tick(spread(16'hFFFF));
    send_tick(spread(16'h0000));
    send_tick(spread(16'h7FFF));
  endtask

  // saturation both ways, zero and full scales, all or no channels inverted
  task automatic test_scale_extremes();
    drain_results();
    write_reg(REG_SPEED_SCALE, 32'hABFF_FFFF);
    write_reg(REG_INVERT_MASK, 32'hF0F0_F0FF);
    send_tick(spread(16'h0000));
    send_tick(spread(16'h7FFF));
    send_tick(spread(16'hFFFF));
    drain_results();
    write_reg(REG_SPEED_SCALE, '0);
    write_reg(REG_ANGLE_SCALE, 32'hFFFF_FFFF);
    write_reg(REG_INVERT_MASK, '0);
    write_reg(REG_UNMAPPED, '1);
    send_tick(spread(16'h1234));
    send_tick(spread(16'h9234));
    send_tick(spread(16'h0000));
    drain_results();
    write_reg(REG_ANGLE_SCALE, '0);
    write_reg(REG_SPEED_SCALE, CFG_DATA_W'(RST_SPEED_SCALE));
    send_tick(spread(16'h4321));
  endtask

  // weight one, zero, above one and a fraction; filter off must hold state
  task automatic test_filter_alpha();
    drain_results();
    write_reg(REG_ANGLE_SCALE, RST_ANGLE_SCALE);
    write_reg(REG_ALPHA, CFG_DATA_W'(ALPHA_ONE));
    write_reg(REG_FILTER_ENABLE, 32'd1);
    send_tick(spread(16'h0100));
    send_tick(spread(16'h0180));
    drain_results();
    write_reg(REG_ALPHA, '0);
    send_tick(spread(16'h0200));
    drain_results();
    write_reg(REG_ALPHA, 32'h0001_FFFF);
    send_tick(spread(16'h0100));
    drain_results();
    write_reg(REG_ALPHA, 32'h0000_4000);
    send_tick(spread(16'h0400));
    send_tick(spread(16'hFC00));
    send_tick(spread(16'hFC00));
    drain_results();
    write_reg(REG_FILTER_ENABLE, '0);
    send_tick(spread(16'h0800));
    drain_results();
    write_reg(REG_FILTER_ENABLE, 32'd1);
    send_tick(spread(16'h0810));
  endtask

  // stall the output long enough to fill the block, then let it drain
  task automatic test_backpressure();
    drain_results();
    holdoff_reqs++;
    repeat (24) send_tick(next_counts(300));
    drain_results();
  endtask

  task automatic test_random_ticks();
    int span;
    int burst;
    int sent;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain_results();
      for (int r = REG_SPEED_SCALE; r <= REG_INVERT_MASK; r++)
        write_reg(CFG_IDX_W'(r), pick_reg_value(CFG_IDX_W'(r)));
      if ($urandom_range(2) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_UNMAPPED, REG_INVERT_MASK + 1)), $urandom);
      if (phase == RAND_PHASES / 2) holdoff_reqs++;
      case (phase % 4)
        0: span = 4;
        1: span = 300;
        2: span = 4000;
        default: span = 32767;
      endcase
      burst = 0;
      sent  = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if (burst == 0) begin
          pause($urandom_range(25, 1));
          burst = ($urandom_range(4) == 0) ? $urandom_range(120, 60) : $urandom_range(20, 1);
        end
        send_tick(next_counts(span));
        sent++;
        burst--;
      end
    end
  endtask

  task automatic finish_run();
    drain_results();
    repeat (LAT_CYCLES + 10) @(posedge clk);
    mismatch_count += expected_ticks.size();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  endtask

  initial begin
    restore_defaults();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_ticks();
    test_scale_extremes();
    test_filter_alpha();
    test_backpressure();
    test_random_ticks();
    finish_run();
  end

endmodule
